/* rtl/core/ddwt_pkg.sv */
// Package for the differential-drive wheel trajectory block.
// Holds fixed-point constants, the controller state type and command/status structs.
// No dependencies.
package ddwt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int OFFSET_SHIFT = 15;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_OFF_SIN,
    ST_OFF_COS,
    ST_POS,
    ST_DSQ_LX,
    ST_DSQ_LY,
    ST_DSQ_RX,
    ST_DSQ_RY,
    ST_SQRT_L,
    ST_SQRT_R,
    ST_DIV_LV,
    ST_DIV_RV,
    ST_DIV_LA,
    ST_DIV_RA,
    ST_DIV_LJ,
    ST_DIV_RJ,
    ST_COMMIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    state_t op;
    logic   start;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } status_t;

endpackage

/* rtl/core/ddwt_ctrl.sv */
// Controller state machine for the wheel trajectory block.
// Sequences the datapath steps; depends on ddwt_pkg.
module ddwt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              first,
  input  logic              out_fire,
  input  ddwt_pkg::status_t status,
  output ddwt_pkg::cmd_t    cmd,
  output logic              in_ready,
  output logic              out_valid
);

  ddwt_pkg::state_t state;
  ddwt_pkg::state_t state_next;
  logic             waiting;
  logic             waiting_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ddwt_pkg::ST_IDLE;
      waiting <= 1'b0;
    end else begin
      state <= state_next;
      waiting <= waiting_next;
    end
  end

  always_comb begin
    state_next = state;
    waiting_next = 1'b0;
    cmd.op = state;
    cmd.start = 1'b0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ddwt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          state_next = ddwt_pkg::ST_OFF_SIN;
        end
      end
      ddwt_pkg::ST_OFF_SIN: state_next = ddwt_pkg::ST_OFF_COS;
      ddwt_pkg::ST_OFF_COS: state_next = ddwt_pkg::ST_POS;
      ddwt_pkg::ST_POS: state_next = first ? ddwt_pkg::ST_COMMIT : ddwt_pkg::ST_DSQ_LX;
      ddwt_pkg::ST_DSQ_LX: state_next = ddwt_pkg::ST_DSQ_LY;
      ddwt_pkg::ST_DSQ_LY: state_next = ddwt_pkg::ST_DSQ_RX;
      ddwt_pkg::ST_DSQ_RX: state_next = ddwt_pkg::ST_DSQ_RY;
      ddwt_pkg::ST_DSQ_RY: state_next = ddwt_pkg::ST_SQRT_L;
      ddwt_pkg::ST_SQRT_L, ddwt_pkg::ST_SQRT_R, ddwt_pkg::ST_DIV_LV, ddwt_pkg::ST_DIV_RV,
      ddwt_pkg::ST_DIV_LA, ddwt_pkg::ST_DIV_RA, ddwt_pkg::ST_DIV_LJ,
      ddwt_pkg::ST_DIV_RJ: begin
        cmd.start = !waiting;
        waiting_next = 1'b1;
        if (waiting && !status.busy) begin
          waiting_next = 1'b0;
          state_next = (state == ddwt_pkg::ST_DIV_RJ) ? ddwt_pkg::ST_COMMIT
                                                       : ddwt_pkg::state_t'(state + 5'd1);
        end
      end
      ddwt_pkg::ST_COMMIT: state_next = ddwt_pkg::ST_OUT;
      ddwt_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_fire) begin
          state_next = ddwt_pkg::ST_IDLE;
        end
      end
      default: state_next = ddwt_pkg::ST_IDLE;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == ddwt_pkg::ST_IDLE) else $error("ready outside idle");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready and valid together");
  a_start_pulse: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> !cmd.start) else $error("start held");
  a_out_after_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ddwt_pkg::ST_COMMIT) else $error("bad out entry");

endmodule

/* rtl/core/ddwt_dp.sv */
// Datapath of the wheel trajectory block: offsets, squares, square root and divider.
// Iterative units run one step a cycle; depends on ddwt_pkg.
module ddwt_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic [183:0]      in_data,
  input  logic [31:0]       track_width,
  input  ddwt_pkg::cmd_t    cmd,
  output ddwt_pkg::status_t status,
  output logic [383:0]      out_data
);

  // input capture
  logic [31:0] t_in;
  logic signed [31:0] cx, cy;
  logic signed [15:0] sn, cs;
  logic first_in;

  // state
  logic [31:0] prev_time;
  logic signed [31:0] plx, ply, prx, pry;
  logic signed [31:0] plv, prv, pla, pra;
  logic [31:0] lsum, rsum;

  // work
  logic signed [49:0] os, oc;
  logic signed [31:0] lx, ly, rx, ry;
  logic [63:0] sq_lx, sq_ly, sq_rx, sq_ry;
  logic [31:0] ld, rd;
  logic signed [31:0] lv, rv, la, ra, lj, rj;
  logic [31:0] dt;

  // multiplier operands
  logic signed [32:0] ma, mb;
  logic signed [65:0] mprod;
  assign mprod = ma * mb;

  // signed differences
  logic signed [32:0] dlx, dly, drx, dry;
  assign dlx = {lx[31], lx} - {plx[31], plx};
  assign dly = {ly[31], ly} - {ply[31], ply};
  assign drx = {rx[31], rx} - {prx[31], prx};
  assign dry = {ry[31], ry} - {pry[31], pry};

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    if (v > 51'sd2147483647) return 32'sh7fffffff;
    if (v < -51'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [32:0] abs33(input logic signed [32:0] v);
    return v[32] ? -v : v;
  endfunction

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      ddwt_pkg::ST_OFF_SIN: begin ma = {1'b0, track_width}; mb = 33'(sn); end
      ddwt_pkg::ST_OFF_COS: begin ma = {1'b0, track_width}; mb = 33'(cs); end
      ddwt_pkg::ST_DSQ_LX: begin ma = abs33(dlx); mb = abs33(dlx); end
      ddwt_pkg::ST_DSQ_LY: begin ma = abs33(dly); mb = abs33(dly); end
      ddwt_pkg::ST_DSQ_RX: begin ma = abs33(drx); mb = abs33(drx); end
      ddwt_pkg::ST_DSQ_RY: begin ma = abs33(dry); mb = abs33(dry); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // square root unit: one result bit per cycle
  logic [64:0] sq_v, sq_r, sq_b;
  logic        sq_busy, sq_sat;
  logic [64:0] sq_sum;
  assign sq_sum = {1'b0, sq_lx} + {1'b0, sq_ly};
  logic [64:0] sq_sum_r;
  assign sq_sum_r = {1'b0, sq_rx} + {1'b0, sq_ry};

  // divider: 64-bit magnitude by 32-bit, one quotient bit per cycle
  logic [63:0] dv_num;
  logic [32:0] dv_rem;
  logic [6:0]  dv_cnt;
  logic        dv_busy, dv_neg, dv_zero;
  logic [64:0] dv_q;
  logic [33:0] dv_try;
  assign dv_try = {dv_rem, dv_num[63]} - {2'b0, dt};

  logic signed [48:0] dv_src;
  logic [47:0] dv_mag;
  logic signed [32:0] dv_diff;
  always_comb begin
    case (cmd.op)
      ddwt_pkg::ST_DIV_LV: dv_diff = {1'b0, ld};
      ddwt_pkg::ST_DIV_RV: dv_diff = {1'b0, rd};
      ddwt_pkg::ST_DIV_LA: dv_diff = {lv[31], lv} - {plv[31], plv};
      ddwt_pkg::ST_DIV_RA: dv_diff = {rv[31], rv} - {prv[31], prv};
      ddwt_pkg::ST_DIV_LJ: dv_diff = {la[31], la} - {pla[31], pla};
      ddwt_pkg::ST_DIV_RJ: dv_diff = {ra[31], ra} - {pra[31], pra};
      default: dv_diff = '0;
    endcase
    dv_src = 49'(dv_diff) <<< ddwt_pkg::FRAC_BITS;
    dv_mag = dv_src[48] ? 48'(-dv_src) : dv_src[47:0];
  end

  logic signed [31:0] dv_res;
  always_comb begin
    logic signed [65:0] sq;
    sq = dv_neg ? -$signed({1'b0, dv_q}) : $signed({1'b0, dv_q});
    if (dv_zero) begin
      dv_res = '0;
    end else if (dt == 32'd0) begin
      dv_res = dv_neg ? 32'sh80000000 : 32'sh7fffffff;
    end else if (sq > 66'sd2147483647) begin
      dv_res = 32'sh7fffffff;
    end else if (sq < -66'sd2147483648) begin
      dv_res = 32'sh80000000;
    end else begin
      dv_res = sq[31:0];
    end
  end

  assign status.busy = sq_busy | dv_busy;

  logic [31:0] sq_res;
  assign sq_res = (sq_sat || sq_r[64:32] != '0) ? 32'hffffffff : sq_r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time <= '0;
      plx <= '0; ply <= '0; prx <= '0; pry <= '0;
      plv <= '0; prv <= '0; pla <= '0; pra <= '0;
      lsum <= '0; rsum <= '0;
      sq_busy <= 1'b0;
      dv_busy <= 1'b0;
    end else begin
      if (in_fire) begin
        t_in <= in_data[31:0];
        cx <= in_data[63:32];
        cy <= in_data[95:64];
        sn <= in_data[111:96];
        cs <= in_data[127:112];
        first_in <= in_data[128];
        lv <= '0; rv <= '0; la <= '0; ra <= '0; lj <= '0; rj <= '0;
        ld <= '0; rd <= '0;
      end
      case (cmd.op)
        ddwt_pkg::ST_OFF_SIN:
          os <= $signed(mprod[49:0] + 50'sd16384) >>> ddwt_pkg::OFFSET_SHIFT;
        ddwt_pkg::ST_OFF_COS: begin
          oc <= $signed(mprod[49:0] + 50'sd16384) >>> ddwt_pkg::OFFSET_SHIFT;
          dt <= t_in - prev_time;
        end
        ddwt_pkg::ST_POS: begin
          lx <= sat32(51'(cx) - 51'(os));
          ly <= sat32(51'(cy) + 51'(oc));
          rx <= sat32(51'(cx) + 51'(os));
          ry <= sat32(51'(cy) - 51'(oc));
        end
        ddwt_pkg::ST_DSQ_LX: sq_lx <= mprod[63:0];
        ddwt_pkg::ST_DSQ_LY: sq_ly <= mprod[63:0];
        ddwt_pkg::ST_DSQ_RX: sq_rx <= mprod[63:0];
        ddwt_pkg::ST_DSQ_RY: sq_ry <= mprod[63:0];
        default: ;
      endcase
      // square root
      if (cmd.start && (cmd.op == ddwt_pkg::ST_SQRT_L || cmd.op == ddwt_pkg::ST_SQRT_R)) begin
        sq_v <= (cmd.op == ddwt_pkg::ST_SQRT_L) ? sq_sum : sq_sum_r;
        sq_sat <= (cmd.op == ddwt_pkg::ST_SQRT_L) ? sq_sum[64] : sq_sum_r[64];
        sq_r <= '0;
        sq_b <= 65'd1 << 62;
        sq_busy <= 1'b1;
      end else if (sq_busy) begin
        if (sq_b == '0) begin
          sq_busy <= 1'b0;
          if (cmd.op == ddwt_pkg::ST_SQRT_L) ld <= sq_res;
          else rd <= sq_res;
        end else begin
          if (sq_v >= sq_r + sq_b) begin
            sq_v <= sq_v - (sq_r + sq_b);
            sq_r <= (sq_r >> 1) + sq_b;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_b <= sq_b >> 2;
        end
      end
      // divider
      if (cmd.start && cmd.op >= ddwt_pkg::ST_DIV_LV && cmd.op <= ddwt_pkg::ST_DIV_RJ) begin
        dv_num <= {16'b0, dv_mag};
        dv_rem <= '0;
        dv_q <= '0;
        dv_cnt <= 7'd64;
        dv_neg <= dv_src[48];
        dv_zero <= (dv_src == '0);
        dv_busy <= 1'b1;
      end else if (dv_busy) begin
        if (dv_cnt == 7'd0) begin
          dv_busy <= 1'b0;
          case (cmd.op)
            ddwt_pkg::ST_DIV_LV: lv <= dv_res;
            ddwt_pkg::ST_DIV_RV: rv <= dv_res;
            ddwt_pkg::ST_DIV_LA: la <= dv_res;
            ddwt_pkg::ST_DIV_RA: ra <= dv_res;
            ddwt_pkg::ST_DIV_LJ: lj <= dv_res;
            default: rj <= dv_res;
          endcase
        end else begin
          dv_cnt <= dv_cnt - 7'd1;
          dv_num <= dv_num << 1;
          if (!dv_try[33]) begin
            dv_rem <= dv_try[32:0];
            dv_q <= {dv_q[63:0], 1'b1};
          end else begin
            dv_rem <= {dv_rem[31:0], dv_num[63]};
            dv_q <= {dv_q[63:0], 1'b0};
          end
        end
      end
      if (cmd.op == ddwt_pkg::ST_COMMIT) begin
        prev_time <= t_in;
        plx <= lx; ply <= ly; prx <= rx; pry <= ry;
        plv <= lv; prv <= rv; pla <= la; pra <= ra;
        if (first_in) begin
          lsum <= '0;
          rsum <= '0;
        end else begin
          lsum <= (32'hffffffff - lsum < ld) ? 32'hffffffff : lsum + ld;
          rsum <= (32'hffffffff - rsum < rd) ? 32'hffffffff : rsum + rd;
        end
      end
    end
  end

  assign out_data = {2'b0, rj, ra, rv[30:0], rsum, ry, rx,
                     lj, la, lv[30:0], lsum, ly, lx};

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(sq_busy && dv_busy)) else $error("units overlap");
  a_vel_nonneg: assert property (@(posedge clk) disable iff (rst)
    cmd.op == ddwt_pkg::ST_OUT |-> !lv[31] && !rv[31]) else $error("negative velocity");
  a_sum_mono: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.op) == ddwt_pkg::ST_COMMIT && !first_in |-> lsum >= $past(lsum))
    else $error("travel decreased");

endmodule

/* rtl/core/diff_drive_wheel_trajectory_top.sv */
// Top level of the differential-drive wheel trajectory block.
// Instantiates ddwt_ctrl and ddwt_dp; depends on ddwt_pkg.
//
// One beat on s_axis carries a robot-center path point; one beat on m_axis
// carries the left and right wheel results for it. cfg_we with cfg_wdata sets
// the track width; the user writes it only while the block is idle, unchecked.
// An item passes from input beat to output beat through the offset and
// position steps, four square products on one shared multiplier, two 32-step
// square roots and six 64-step divisions run one after another on one shared
// root unit and one shared restoring divider, and the commit and output steps.
// A point marked first of a path skips the squares, roots and divisions.
// One item is in work at a time; s_axis_tready is high only when the block
// is empty, so the next beat is taken in the cycle after the result beat
// at the earliest. The result holds on m_axis until taken, and a stalled
// receiver simply holds the block. Reset clears the track width, the
// previous point, the motion history and the travel sums to zero.
module diff_drive_wheel_trajectory_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // sample_time, center_x, center_y, heading_sin, heading_cos, first_point, pad
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // left_x, left_y, left_travel, left_velocity, left_accel, left_jerk,
  // right_x, right_y, right_travel, right_velocity, right_accel, right_jerk, pad
  output logic [383:0] m_axis_tdata
);

  logic [31:0]       track_width;
  ddwt_pkg::cmd_t    cmd;
  ddwt_pkg::status_t status;
  logic              in_fire;
  logic              out_fire;
  logic              first_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      track_width <= '0;
    end else if (cfg_we) begin
      track_width <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      first_q <= s_axis_tdata[128];
    end
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  ddwt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .first     (first_q),
    .out_fire  (out_fire),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid)
  );

  ddwt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (in_fire),
    .in_data     ({48'b0, s_axis_tdata}),
    .track_width (track_width),
    .cmd         (cmd),
    .status      (status),
    .out_data    (m_axis_tdata)
  );

endmodule
